// File: hdl/mfde_pkg.sv
// shared types, constants and mask helpers for the monochrome frame draw engine
// depends on nothing; every other file refers to it by scoped names
`default_nettype none

package mfde_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 64;
  localparam int FRAME_HEIGHT = 32;

  localparam int COL_W  = $clog2(FRAME_WIDTH + 1);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT + 1);
  localparam int ADDR_W = $clog2(FRAME_HEIGHT);

  // signed coordinate wide enough for an 8-bit position plus an 8-bit size
  localparam int COORD_W = 11;

  // fixed field widths
  localparam int CMD_W      = 4;
  localparam int POS_W      = 8;
  localparam int SIZE_W     = 8;
  localparam int SPRITE_W   = 64;
  localparam int ROWBITS_W  = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_ROWV_W = 6;

  localparam int IN_FIELDS_W = 2 * POS_W + 2 * SIZE_W + 1 + SPRITE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ROWBITS_W;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SETPIX   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INVPIX   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_FILL     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_OUTLINE  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_HLINE    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_VLINE    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SPR_SET  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SPR_ERA  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_INVRECT  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_READROW  = 4'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

  // pixel operations
  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_CLR = 2'd1;
  localparam logic [1:0] OP_INV = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [FRAME_WIDTH-1:0]    row_t;

  // one drawing job: band a covers rows [a_lo, a_hi), band b rows b0 and b1
  typedef struct packed {
    logic [1:0] op;
    coord_t     a_lo;
    coord_t     a_hi;
    coord_t     b0;
    coord_t     b1;
    row_t       mask_a;
    row_t       mask_b;
  } draw_job_t;

  function automatic logic [COL_W-1:0] clamp_col(input coord_t v);
    logic [COL_W-1:0] r;
    if (v < coord_t'(0)) begin
      r = '0;
    end else if (v > coord_t'(FRAME_WIDTH)) begin
      r = COL_W'(FRAME_WIDTH);
    end else begin
      r = v[COL_W-1:0];
    end
    return r;
  endfunction

  // columns lo..hi-1 within the frame, empty when hi <= lo
  function automatic row_t range_mask(input coord_t lo, input coord_t hi);
    row_t             ones;
    logic [COL_W-1:0] l;
    logic [COL_W-1:0] h;
    ones = '1;
    l    = clamp_col(lo);
    h    = clamp_col(hi);
    return (ones << l) & ~(ones << h);
  endfunction

endpackage

`default_nettype wire

// File: hdl/mfde_store.sv
// frame store memory with per-row valid bits so reset and clear act at once
// depends on mfde_pkg
`default_nettype none

module mfde_store (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          clr,
  input  wire logic                          wr_en,
  input  wire logic [mfde_pkg::ADDR_W-1:0]   wr_addr,
  input  wire mfde_pkg::row_t                wr_data,
  input  wire logic [mfde_pkg::ADDR_W-1:0]   rd_addr,
  output mfde_pkg::row_t                     rd_data
);

  mfde_pkg::row_t                      mem [mfde_pkg::FRAME_HEIGHT];
  logic [mfde_pkg::FRAME_HEIGHT-1:0]   vld_r;
  mfde_pkg::row_t                      rd_q_r;
  logic                                vld_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      vld_q_r <= vld_r[rd_addr];
    end
  end

  // rows never written since reset or clear read as all off
  assign rd_data = vld_q_r ? rd_q_r : '0;

endmodule

`default_nettype wire

// File: hdl/mfde_setup.sv
// turns one command and the clip window into a row band job with column masks
// depends on mfde_pkg
`default_nettype none

module mfde_setup (
  input  wire logic [mfde_pkg::CMD_W-1:0]     cmd,
  input  wire logic signed [mfde_pkg::POS_W-1:0] x_pos,
  input  wire logic signed [mfde_pkg::POS_W-1:0] y_pos,
  input  wire logic [mfde_pkg::SIZE_W-1:0]    rect_width,
  input  wire logic [mfde_pkg::SIZE_W-1:0]    rect_height,
  input  wire logic                           set_level,
  input  wire logic [mfde_pkg::SPRITE_W-1:0]  sprite_bits,
  input  wire logic [mfde_pkg::COL_W-1:0]     clip_left,
  input  wire logic [mfde_pkg::COL_W-1:0]     clip_right,
  output mfde_pkg::draw_job_t                 job
);

  mfde_pkg::coord_t xs, xe, ys, ye, lim;
  mfde_pkg::row_t   cm, hm, pm, vm, sm;
  logic [mfde_pkg::SPRITE_W-1:0] spr_sh;
  logic [mfde_pkg::POS_W-1:0]    sh_neg;

  always_comb begin
    xs   = mfde_pkg::coord_t'(x_pos);
    ys   = mfde_pkg::coord_t'(y_pos);
    xe   = xs + mfde_pkg::coord_t'(rect_width);
    ye   = ys + mfde_pkg::coord_t'(rect_height);
    lim  = (rect_width > mfde_pkg::SIZE_W'(mfde_pkg::SPRITE_W))
           ? mfde_pkg::coord_t'(mfde_pkg::SPRITE_W) : mfde_pkg::coord_t'(rect_width);
    cm   = mfde_pkg::range_mask(mfde_pkg::coord_t'(clip_left),
                                mfde_pkg::coord_t'(clip_right));
    hm   = mfde_pkg::range_mask(xs, xe) & cm;
    pm   = mfde_pkg::range_mask(xs, xs + mfde_pkg::coord_t'(1)) & cm;
    vm   = (mfde_pkg::range_mask(xs, xs + mfde_pkg::coord_t'(1)) |
            mfde_pkg::range_mask(xe - mfde_pkg::coord_t'(1), xe)) & cm;
    // sprite bit i lands on column x_pos + i
    sh_neg = ~x_pos + mfde_pkg::POS_W'(1);
    spr_sh = x_pos[mfde_pkg::POS_W-1] ? (sprite_bits >> sh_neg) : (sprite_bits << x_pos);
    sm     = spr_sh[mfde_pkg::FRAME_WIDTH-1:0] & mfde_pkg::range_mask(xs, xs + lim) & cm;

    job.op     = mfde_pkg::OP_SET;
    job.a_lo   = ys;
    job.a_hi   = ys + mfde_pkg::coord_t'(1);
    job.b0     = ys;
    job.b1     = ys;
    job.mask_a = '0;
    job.mask_b = '0;
    unique case (cmd)
      mfde_pkg::CMD_SETPIX: begin
        job.op     = set_level ? mfde_pkg::OP_SET : mfde_pkg::OP_CLR;
        job.mask_a = pm;
      end
      mfde_pkg::CMD_INVPIX: begin
        job.op     = mfde_pkg::OP_INV;
        job.mask_a = pm;
      end
      mfde_pkg::CMD_FILL: begin
        job.a_hi   = ye;
        job.mask_a = hm;
      end
      mfde_pkg::CMD_INVRECT: begin
        job.op     = mfde_pkg::OP_INV;
        job.a_hi   = ye;
        job.mask_a = hm;
      end
      mfde_pkg::CMD_OUTLINE: begin
        // verticals span the height, horizontals sit at top and bottom row
        job.a_hi   = ye;
        job.mask_a = vm;
        job.b1     = ye - mfde_pkg::coord_t'(1);
        job.mask_b = hm;
      end
      mfde_pkg::CMD_HLINE: begin
        job.mask_a = hm;
      end
      mfde_pkg::CMD_VLINE: begin
        job.a_hi   = ye;
        job.mask_a = pm;
      end
      mfde_pkg::CMD_SPR_SET: begin
        job.mask_a = sm;
      end
      mfde_pkg::CMD_SPR_ERA: begin
        job.op     = mfde_pkg::OP_CLR;
        job.mask_a = sm;
      end
      default: begin
        job.mask_a = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/mfde_row_alu.sv
// shared row unit: selects the column mask for one row and applies the pixel op
// depends on mfde_pkg
`default_nettype none

module mfde_row_alu (
  input  wire mfde_pkg::draw_job_t            job,
  input  wire logic [mfde_pkg::ADDR_W-1:0]    row,
  input  wire mfde_pkg::row_t                 old_bits,
  output mfde_pkg::row_t                      new_bits
);

  mfde_pkg::coord_t r;
  logic             in_a, in_b;
  mfde_pkg::row_t   m;

  always_comb begin
    r    = mfde_pkg::coord_t'({1'b0, row});
    in_a = (r >= job.a_lo) && (r < job.a_hi);
    in_b = (r == job.b0) || (r == job.b1);
    m    = (in_a ? job.mask_a : '0) | (in_b ? job.mask_b : '0);
    unique case (job.op)
      mfde_pkg::OP_SET: new_bits = old_bits | m;
      mfde_pkg::OP_CLR: new_bits = old_bits & ~m;
      mfde_pkg::OP_INV: new_bits = old_bits ^ m;
      default:          new_bits = old_bits;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/mono_framebuffer_draw_engine_unit.sv
// top level of the monochrome frame draw engine: sequencer, clip registers, output
// depends on mfde_pkg, mfde_store, mfde_setup, mfde_row_alu
`default_nettype none

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------
// in_       | slave     | in_tvalid / in_tready  | in_tuser cmd, in_tdata draw fields
// out_      | master    | out_tvalid / out_tready| out_tdata row_bits, out_tuser row_valid
// cfg_      | slave     | cfg_valid / cfg_ready  | cfg_index, cfg_data (clip register)
//
// clear and unused codes finish in the idle state; read row passes the read and read-data
// states to the output register; drawing: a setup state, one row read-modify-write per cycle
// over clip_top..clip_bottom-1 through the store's read and write ports, then a drain state;
// with no row inside the clip window only the setup state is passed
// rst_n is synchronous; it marks every frame row off at once and resets the clip window
// in_tready is high only between commands; a waiting result stalls only a further read

module mono_framebuffer_draw_engine_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // fields from bit 0: x_pos[7:0], y_pos[15:8], rect_width[23:16],
  // rect_height[31:24], set_level[32], sprite_bits[96:33], zero fill
  input  wire logic [mfde_pkg::IN_TDATA_W-1:0]      in_tdata,
  // fields from bit 0: cmd[3:0]
  input  wire logic [mfde_pkg::CMD_W-1:0]           in_tuser,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // fields from bit 0: row_bits[63:0]
  output logic [mfde_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // fields from bit 0: row_valid[0]
  output logic                                      out_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mfde_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mfde_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_RDATA = 3'd5;

  logic [2:0] state_r, state_nxt;

  // command registers
  logic [mfde_pkg::CMD_W-1:0]           cmd_r;
  logic signed [mfde_pkg::POS_W-1:0]    x_r, y_r;
  logic [mfde_pkg::SIZE_W-1:0]          w_r, h_r;
  logic                                 on_r;
  logic [mfde_pkg::SPRITE_W-1:0]        spr_r;

  // clip window
  logic [mfde_pkg::COL_W-1:0]           clip_left_r, clip_right_r;
  logic [mfde_pkg::ROW_W-1:0]           clip_top_r, clip_bottom_r;

  // sweep control
  mfde_pkg::draw_job_t                  job, job_r;
  logic [mfde_pkg::ROW_W-1:0]           row_r, row_nxt;
  logic [mfde_pkg::ADDR_W-1:0]          wr_row_r;
  logic                                 pend_r, pend_nxt;

  // store and output
  logic                                 in_xfer, clr, wr_en, out_load, read_in_frame;
  logic [mfde_pkg::ADDR_W-1:0]          rd_addr;
  mfde_pkg::row_t                       rd_data, wr_data;
  logic [mfde_pkg::ROWBITS_W-1:0]       out_bits_r;
  logic                                 out_rv_r, out_valid_r;
  logic [mfde_pkg::CFG_DATA_W-1:0]      cfg_col;
  logic [mfde_pkg::CFG_ROWV_W-1:0]      cfg_row;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign clr       = in_xfer && (in_tuser == mfde_pkg::CMD_CLEAR);
  assign cfg_ready = 1'b1;

  // payload capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r   <= in_tdata[7:0];
      y_r   <= in_tdata[15:8];
      w_r   <= in_tdata[23:16];
      h_r   <= in_tdata[31:24];
      on_r  <= in_tdata[32];
      spr_r <= in_tdata[96:33];
      cmd_r <= in_tuser;
    end
    if (state_r == S_SETUP) begin
      job_r <= job;
    end
  end

  // clip registers saturate to the frame on write
  assign cfg_col = cfg_data;
  assign cfg_row = cfg_data[mfde_pkg::CFG_ROWV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= mfde_pkg::COL_W'(mfde_pkg::FRAME_WIDTH);
      clip_bottom_r <= mfde_pkg::ROW_W'(mfde_pkg::FRAME_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mfde_pkg::REG_CLIP_LEFT:
          clip_left_r <= (cfg_col > mfde_pkg::CFG_DATA_W'(mfde_pkg::FRAME_WIDTH))
                         ? mfde_pkg::COL_W'(mfde_pkg::FRAME_WIDTH) : mfde_pkg::COL_W'(cfg_col);
        mfde_pkg::REG_CLIP_RIGHT:
          clip_right_r <= (cfg_col > mfde_pkg::CFG_DATA_W'(mfde_pkg::FRAME_WIDTH))
                          ? mfde_pkg::COL_W'(mfde_pkg::FRAME_WIDTH) : mfde_pkg::COL_W'(cfg_col);
        mfde_pkg::REG_CLIP_TOP:
          clip_top_r <= (32'(cfg_row) > 32'(mfde_pkg::FRAME_HEIGHT))
                        ? mfde_pkg::ROW_W'(mfde_pkg::FRAME_HEIGHT) : mfde_pkg::ROW_W'(cfg_row);
        mfde_pkg::REG_CLIP_BOTTOM:
          clip_bottom_r <= (32'(cfg_row) > 32'(mfde_pkg::FRAME_HEIGHT))
                           ? mfde_pkg::ROW_W'(mfde_pkg::FRAME_HEIGHT) : mfde_pkg::ROW_W'(cfg_row);
        default: clip_left_r <= clip_left_r;
      endcase
    end
  end

  mfde_setup u_setup (
    .cmd         (cmd_r),
    .x_pos       (x_r),
    .y_pos       (y_r),
    .rect_width  (w_r),
    .rect_height (h_r),
    .set_level   (on_r),
    .sprite_bits (spr_r),
    .clip_left   (clip_left_r),
    .clip_right  (clip_right_r),
    .job         (job)
  );

  mfde_row_alu u_row_alu (
    .job      (job_r),
    .row      (wr_row_r),
    .old_bits (rd_data),
    .new_bits (wr_data)
  );

  // read address follows the sweep row, otherwise the requested read row
  assign rd_addr = (state_r == S_SWEEP) ? row_r[mfde_pkg::ADDR_W-1:0]
                                        : y_r[mfde_pkg::ADDR_W-1:0];
  assign wr_en   = pend_r;

  mfde_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr),
    .wr_en   (wr_en),
    .wr_addr (wr_row_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign read_in_frame = (y_r >= 0) && (32'(y_r) < mfde_pkg::FRAME_HEIGHT);
  assign out_load      = (state_r == S_RDATA) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    pend_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (in_tuser == mfde_pkg::CMD_CLEAR) begin
            state_nxt = S_IDLE;
          end else if (in_tuser == mfde_pkg::CMD_READROW) begin
            state_nxt = S_READ;
          end else if (in_tuser > mfde_pkg::CMD_READROW) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        row_nxt   = clip_top_r;
        // empty row window draws nothing
        state_nxt = (clip_top_r < clip_bottom_r) ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        pend_nxt = 1'b1;
        row_nxt  = row_r + mfde_pkg::ROW_W'(1);
        if (row_nxt == clip_bottom_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      S_READ: begin
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // row just read is written back in the following cycle
  always_ff @(posedge clk) begin
    if (state_r == S_SWEEP) begin
      wr_row_r <= row_r[mfde_pkg::ADDR_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bits_r <= read_in_frame ? mfde_pkg::ROWBITS_W'(rd_data) : '0;
      out_rv_r   <= read_in_frame;
    end
  end

  assign out_tdata  = out_bits_r;
  assign out_tuser  = out_rv_r;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for mono_framebuffer_draw_engine_unit
// keeps a shadow frame store and clip window, predicts every row read, checks each returned row
// depends on mfde_pkg and the draw engine rtl only
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_LEN   = 8;
  // longest drawing command is a setup state, FRAME_HEIGHT row passes and a drain state
  localparam int DRAIN_LEN   = mfde_pkg::FRAME_HEIGHT + 8;
  localparam int PHASE_ITEMS = 190;
  localparam int TIMEOUT_NS  = 5_000_000;

  // one drawing command as the sender presents it
  typedef struct packed {
    logic [mfde_pkg::CMD_W-1:0]    cmd;
    logic [mfde_pkg::POS_W-1:0]    x_pos;
    logic [mfde_pkg::POS_W-1:0]    y_pos;
    logic [mfde_pkg::SIZE_W-1:0]   rect_width;
    logic [mfde_pkg::SIZE_W-1:0]   rect_height;
    logic                          set_level;
    logic [mfde_pkg::SPRITE_W-1:0] sprite_bits;
  } draw_req_t;

  // one row read result
  typedef struct packed {
    logic [mfde_pkg::ROWBITS_W-1:0] row_bits;
    logic                           row_valid;
  } row_read_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [mfde_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [mfde_pkg::CMD_W-1:0]       in_tuser = mfde_pkg::CMD_CLEAR;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [mfde_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mfde_pkg::CFG_IDX_W-1:0]   cfg_index = mfde_pkg::REG_CLIP_LEFT;
  logic [mfde_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  mono_framebuffer_draw_engine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the block: frame store and saturated clip window
  logic [mfde_pkg::FRAME_WIDTH-1:0] shadow_frame [mfde_pkg::FRAME_HEIGHT];
  int win_left   = 0;
  int win_top    = 0;
  int win_right  = mfde_pkg::FRAME_WIDTH;
  int win_bottom = mfde_pkg::FRAME_HEIGHT;

  draw_req_t pending_cmds [$];   // commands waiting for the driver
  row_read_t expected_rows [$];  // predicted rows, oldest first
  draw_req_t active_cmd;         // command currently on the input bus
  row_read_t want_row;

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int cmds_accepted = 0;
  int rows_checked  = 0;
  int clip_writes   = 0;
  int windows_set   = 0;
  int mismatches    = 0;

  initial begin
    for (int r = 0; r < mfde_pkg::FRAME_HEIGHT; r++) shadow_frame[r] = '0;
  end

  // set, clear or invert a rectangle of pixels, dropping whatever falls outside
  // the frame or the clip window; the window is already saturated to the frame
  task automatic paint_rect(input int x, input int y, input int w, input int h,
                            input logic [1:0] op);
    logic [mfde_pkg::FRAME_WIDTH-1:0] cols;
    int c_lo, c_hi, r_lo, r_hi;
    c_lo = (x > win_left) ? x : win_left;
    c_hi = (x + w < win_right) ? x + w : win_right;
    r_lo = (y > win_top) ? y : win_top;
    r_hi = (y + h < win_bottom) ? y + h : win_bottom;
    cols = '0;
    for (int c = c_lo; c < c_hi; c++) cols[c] = 1'b1;
    for (int r = r_lo; r < r_hi; r++) begin
      case (op)
        mfde_pkg::OP_SET: shadow_frame[r] = shadow_frame[r] | cols;
        mfde_pkg::OP_CLR: shadow_frame[r] = shadow_frame[r] & ~cols;
        default:          shadow_frame[r] = shadow_frame[r] ^ cols;
      endcase
    end
  endtask

  // update the shadow frame for one accepted command, queue a row if it reads one
  task automatic apply_draw_cmd(input draw_req_t c);
    int x, y, w, h, lim;
    row_read_t rd;
    x = int'($signed(c.x_pos));
    y = int'($signed(c.y_pos));
    w = int'(c.rect_width);
    h = int'(c.rect_height);
    case (c.cmd)
      mfde_pkg::CMD_CLEAR: begin
        // whole frame, clip window does not apply
        for (int r = 0; r < mfde_pkg::FRAME_HEIGHT; r++) shadow_frame[r] = '0;
      end
      mfde_pkg::CMD_SETPIX:
        paint_rect(x, y, 1, 1, c.set_level ? mfde_pkg::OP_SET : mfde_pkg::OP_CLR);
      mfde_pkg::CMD_INVPIX:  paint_rect(x, y, 1, 1, mfde_pkg::OP_INV);
      mfde_pkg::CMD_FILL:    paint_rect(x, y, w, h, mfde_pkg::OP_SET);
      mfde_pkg::CMD_OUTLINE: begin
        // two horizontal and two vertical lines; zero sizes land on x-1 or y-1
        paint_rect(x, y, w, 1, mfde_pkg::OP_SET);
        paint_rect(x, y + h - 1, w, 1, mfde_pkg::OP_SET);
        paint_rect(x, y, 1, h, mfde_pkg::OP_SET);
        paint_rect(x + w - 1, y, 1, h, mfde_pkg::OP_SET);
      end
      mfde_pkg::CMD_HLINE:   paint_rect(x, y, w, 1, mfde_pkg::OP_SET);
      mfde_pkg::CMD_VLINE:   paint_rect(x, y, 1, h, mfde_pkg::OP_SET);
      mfde_pkg::CMD_SPR_SET, mfde_pkg::CMD_SPR_ERA: begin
        // mask bits past the top of the sprite word are never drawn
        lim = (w < mfde_pkg::SPRITE_W) ? w : mfde_pkg::SPRITE_W;
        for (int i = 0; i < lim; i++) begin
          if (c.sprite_bits[i]) begin
            paint_rect(x + i, y, 1, 1, (c.cmd == mfde_pkg::CMD_SPR_SET) ? mfde_pkg::OP_SET
                                                                         : mfde_pkg::OP_CLR);
          end
        end
      end
      mfde_pkg::CMD_INVRECT: paint_rect(x, y, w, h, mfde_pkg::OP_INV);
      mfde_pkg::CMD_READROW: begin
        if (y >= 0 && y < mfde_pkg::FRAME_HEIGHT) begin
          rd = '{row_bits: shadow_frame[y], row_valid: 1'b1};
        end else begin
          rd = '{row_bits: '0, row_valid: 1'b0};
        end
        expected_rows.push_back(rd);
      end
      default: ;  // unused codes are dropped
    endcase
  endtask

  // input driver: a transfer completes on tvalid and tready, then the next command is loaded
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_draw_cmd(active_cmd);
        cmds_accepted++;
      end
      // bus may only change when nothing is on it or it was just taken
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          active_cmd = pending_cmds.pop_front();
          in_tuser  <= active_cmd.cmd;
          // x_pos, y_pos, rect_width, rect_height, set_level, sprite_bits from bit 0, zero fill
          in_tdata  <= mfde_pkg::IN_TDATA_W'({active_cmd.sprite_bits, active_cmd.set_level,
                                              active_cmd.rect_height, active_cmd.rect_width,
                                              active_cmd.y_pos, active_cmd.x_pos});
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: each row transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_rows.size() == 0) begin
          $error("row result with no read pending: row_bits %h row_valid %b",
                 out_tdata, out_tuser);
          mismatches++;
        end else begin
          want_row = expected_rows.pop_front();
          if (out_tdata !== want_row.row_bits) begin
            $error("row_bits mismatch: expected %h, actual %h", want_row.row_bits, out_tdata);
            mismatches++;
          end
          if (out_tuser !== want_row.row_valid) begin
            $error("row_valid mismatch: expected %b, actual %b", want_row.row_valid, out_tuser);
            mismatches++;
          end
          rows_checked++;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic draw_req_t make_req(input logic [mfde_pkg::CMD_W-1:0] cmd,
                                         input int x, input int y,
                                         input int w, input int h, input logic on,
                                         input logic [mfde_pkg::SPRITE_W-1:0] bits);
    draw_req_t c;
    c.cmd         = cmd;
    c.x_pos       = mfde_pkg::POS_W'(x);
    c.y_pos       = mfde_pkg::POS_W'(y);
    c.rect_width  = mfde_pkg::SIZE_W'(w);
    c.rect_height = mfde_pkg::SIZE_W'(h);
    c.set_level   = on;
    c.sprite_bits = bits;
    return c;
  endfunction

  // mostly coordinates around the frame and modest sizes, now and then the full range
  function automatic draw_req_t random_cmd();
    draw_req_t c;
    int pick;
    pick = $urandom_range(99);
    c.sprite_bits = {$urandom, $urandom};
    c.set_level   = 1'($urandom_range(1));
    c.x_pos = ($urandom_range(7) == 0) ? mfde_pkg::POS_W'($urandom)
                                       : mfde_pkg::POS_W'($urandom_range(0, 79) - 8);
    c.y_pos = ($urandom_range(7) == 0) ? mfde_pkg::POS_W'($urandom)
                                       : mfde_pkg::POS_W'($urandom_range(0, 43) - 6);
    c.rect_width  = ($urandom_range(9) == 0) ? mfde_pkg::SIZE_W'($urandom)
                                             : mfde_pkg::SIZE_W'($urandom_range(0, 24));
    c.rect_height = ($urandom_range(9) == 0) ? mfde_pkg::SIZE_W'($urandom)
                                             : mfde_pkg::SIZE_W'($urandom_range(0, 12));
    if (pick < 30) begin
      c.cmd = mfde_pkg::CMD_READROW;
      if ($urandom_range(7) != 0) begin
        c.y_pos = mfde_pkg::POS_W'($urandom_range(0, mfde_pkg::FRAME_HEIGHT - 1));
      end
    end else if (pick < 32) begin
      c.cmd = mfde_pkg::CMD_CLEAR;
    end else if (pick < 34) begin
      // unused codes
      c.cmd = mfde_pkg::CMD_READROW + mfde_pkg::CMD_W'($urandom_range(1, 5));
    end else begin
      c.cmd = mfde_pkg::CMD_SETPIX +
              mfde_pkg::CMD_W'($urandom_range(0, mfde_pkg::CMD_INVRECT - mfde_pkg::CMD_SETPIX));
      if (c.cmd == mfde_pkg::CMD_SPR_SET || c.cmd == mfde_pkg::CMD_SPR_ERA) begin
        if ($urandom_range(9) != 0) c.rect_width = mfde_pkg::SIZE_W'($urandom_range(0, 72));
      end
    end
    return c;
  endfunction

  // program all four clip registers, one transfer each; block must be idle
  task automatic set_window(input logic [mfde_pkg::CFG_DATA_W-1:0] l,
                            input logic [mfde_pkg::CFG_DATA_W-1:0] t,
                            input logic [mfde_pkg::CFG_DATA_W-1:0] r,
                            input logic [mfde_pkg::CFG_DATA_W-1:0] b);
    logic [mfde_pkg::CFG_DATA_W-1:0] vals [4];
    logic [mfde_pkg::CFG_IDX_W-1:0]  regs [4];
    vals = '{l, t, r, b};
    regs = '{mfde_pkg::REG_CLIP_LEFT, mfde_pkg::REG_CLIP_TOP,
             mfde_pkg::REG_CLIP_RIGHT, mfde_pkg::REG_CLIP_BOTTOM};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      // columns saturate at the frame width, rows keep six bits and saturate at the height
      case (regs[i])
        mfde_pkg::REG_CLIP_LEFT:
          win_left = (vals[i] > mfde_pkg::FRAME_WIDTH) ? mfde_pkg::FRAME_WIDTH : int'(vals[i]);
        mfde_pkg::REG_CLIP_TOP:
          win_top = (vals[i][5:0] > mfde_pkg::FRAME_HEIGHT) ? mfde_pkg::FRAME_HEIGHT
                                                            : int'(vals[i][5:0]);
        mfde_pkg::REG_CLIP_RIGHT:
          win_right = (vals[i] > mfde_pkg::FRAME_WIDTH) ? mfde_pkg::FRAME_WIDTH : int'(vals[i]);
        mfde_pkg::REG_CLIP_BOTTOM:
          win_bottom = (vals[i][5:0] > mfde_pkg::FRAME_HEIGHT) ? mfde_pkg::FRAME_HEIGHT
                                                               : int'(vals[i][5:0]);
        default: ;
      endcase
      clip_writes++;
    end
    windows_set++;
  endtask

  // queue n random commands under the given idling, then wait until the block is quiet
  task automatic run_phase(input int n, input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) pending_cmds.push_back(random_cmd());
    do @(posedge clk); while (pending_cmds.size() != 0 || in_tvalid || expected_rows.size() != 0);
    // a trailing drawing command may still be sweeping rows
    repeat (DRAIN_LEN) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset window
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, 0, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_SETPIX, 0, 0, 0, 0, 1'b1, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_SETPIX, 63, 31, 0, 0, 1'b1, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_SETPIX, -128, -128, 255, 255, 1'b1, '1));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_SETPIX, 127, 127, 0, 0, 1'b1, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_INVPIX, 1, 0, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_SETPIX, 0, 0, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, 0, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, 31, 0, 0, 1'b0, '0));
    // fill from far outside covering the whole frame, then invert an inner box
    pending_cmds.push_back(make_req(mfde_pkg::CMD_FILL, -128, -128, 255, 255, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_INVRECT, 2, 2, 60, 28, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, 2, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_CLEAR, 0, 0, 0, 0, 1'b0, '0));
    // outline with zero width gives columns x and x-1, zero height rows y and y-1
    pending_cmds.push_back(make_req(mfde_pkg::CMD_OUTLINE, 5, 4, 0, 3, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_OUTLINE, 20, 10, 6, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_OUTLINE, 30, 12, 10, 6, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_HLINE, 60, 20, 255, 255, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_VLINE, 40, -5, 255, 255, 1'b0, '0));
    // sprite width past its 64 mask bits, then a partial erase of it
    pending_cmds.push_back(make_req(mfde_pkg::CMD_SPR_SET, -8, 25, 255, 0, 1'b0, '1));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_SPR_ERA, 10, 25, 8, 0, 1'b0, 64'hA5));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, 25, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, 4, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, 9, 0, 0, 1'b0, '0));
    // unused codes and reads outside the frame
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW + 4'd1, 3, 3, 3, 3, 1'b1, '1));
    pending_cmds.push_back(make_req('1, 3, 3, 3, 3, 1'b1, '1));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, -1, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, 32, 0, 0, 1'b0, '0));
    pending_cmds.push_back(make_req(mfde_pkg::CMD_READROW, 0, -128, 0, 0, 1'b0, '0));
    run_phase(0, 0, 0);

    // over-range values: left and right saturate to the frame width, leaving no column; no idling
    set_window(7'h7F, 7'h00, 7'h7F, 7'h7F);
    run_phase(PHASE_ITEMS, 0, 0);

    // partial window, sender idles
    set_window(7'($urandom_range(0, 48)), 7'($urandom_range(0, 24)),
               7'($urandom_range(16, 127)), 7'($urandom_range(8, 63)));
    run_phase(PHASE_ITEMS, 55, 0);

    // any register values at all, receiver stalls
    set_window(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
               7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    run_phase(PHASE_ITEMS, 0, 55);

    // empty window, left past right, both sides idle a little
    set_window(7'd40, 7'd0, 7'd20, 7'd32);
    run_phase(PHASE_ITEMS, 7, 7);

    // row registers keep only six bits: top 5, bottom 26
    set_window(7'd3, 7'h45, 7'd61, 7'h5A);
    run_phase(PHASE_ITEMS, 55, 0);

    // exact frame extremes; sender holds off halfway until every row is back
    set_window(7'd0, 7'd0, 7'(mfde_pkg::FRAME_WIDTH), 7'(mfde_pkg::FRAME_HEIGHT));
    run_phase(PHASE_ITEMS / 2, 0, 0);
    run_phase(PHASE_ITEMS / 2, 0, 55);

    // window collapsed onto the far frame edges
    set_window(7'(mfde_pkg::FRAME_WIDTH), 7'(mfde_pkg::FRAME_HEIGHT),
               7'(mfde_pkg::FRAME_WIDTH), 7'(mfde_pkg::FRAME_HEIGHT));
    run_phase(PHASE_ITEMS, 7, 7);

    $display("covered %0d drawing and read commands over %0d clip windows (%0d register writes)",
             cmds_accepted, windows_set, clip_writes);
    $display("checked %0d returned rows under steady, sender-idle, receiver-stall and mixed flow",
             rows_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d rows still expected, %0d commands still queued",
             expected_rows.size(), pending_cmds.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hdl/mfde_pkg.sv
hdl/mfde_store.sv
hdl/mfde_setup.sv
hdl/mfde_row_alu.sv
hdl/mono_framebuffer_draw_engine_unit.sv
dv/tb.sv
